@@ rtl/dafmt_pkg.sv @@
package dafmt_pkg;

	localparam int unsigned NUM_DIGITS = 5;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned LEN_W      = 3;

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_POINT = 8'h2E;

	localparam logic MODE_INT   = 1'b0;
	localparam logic MODE_FIXED = 1'b1;

	// weight of each cell along the chain, most significant first
	localparam logic [13:0] WEIGHT [NUM_DIGITS] = '{
		14'd10000, 14'd1000, 14'd100, 14'd10, 14'd1
	};

	// word handed from one cell to the next
	typedef struct packed {
		logic                              valid;
		logic                              mode;
		logic [LEN_W-1:0]                  len;
		logic [15:0]                       rem;
		logic [NUM_DIGITS*DIGIT_W-1:0]     digits;
	} cell_word_t;

endpackage

@@ rtl/dafmt_cell.sv @@
module dafmt_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [13:0]            weight,
	input  dafmt_pkg::cell_word_t  din,
	output dafmt_pkg::cell_word_t  dout
);

	logic [dafmt_pkg::DIGIT_W-1:0] digit;
	logic [15:0]                   rem_next;
	logic                          valid_q;
	logic                          mode_q;
	logic [dafmt_pkg::LEN_W-1:0]   len_q;
	logic [15:0]                   rem_q;
	logic [dafmt_pkg::NUM_DIGITS*dafmt_pkg::DIGIT_W-1:0] digits_q;

	// independent compares against the nine multiples of this cell's weight
	always_comb begin
		digit = '0;
		for (int k = 1; k < 10; k++) begin
			if ({1'b0, din.rem} >= 17'(k) * {3'b000, weight}) begin
				digit = dafmt_pkg::DIGIT_W'(k);
			end
		end
		rem_next = 16'({1'b0, din.rem} - 17'(digit) * {3'b000, weight});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	// shift the new digit in at the low end
	always_ff @(posedge clk) begin
		mode_q   <= din.mode;
		len_q    <= din.len;
		rem_q    <= rem_next;
		digits_q <= {din.digits[(dafmt_pkg::NUM_DIGITS-1)*dafmt_pkg::DIGIT_W-1:0], digit};
	end

	assign dout.valid  = valid_q;
	assign dout.mode   = mode_q;
	assign dout.len    = len_q;
	assign dout.rem    = rem_q;
	assign dout.digits = digits_q;

endmodule

@@ rtl/dafmt_emitter.sv @@
module dafmt_emitter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dafmt_pkg::cell_word_t din,
	output logic                  char_valid,
	output logic [7:0]            char_code,
	output logic                  last_char
);

	logic [dafmt_pkg::DIGIT_W-1:0] dig [dafmt_pkg::NUM_DIGITS];
	logic [7:0]                    ch  [dafmt_pkg::NUM_DIGITS];
	logic [2:0]                    first;
	logic [7:0]                    chars_q [dafmt_pkg::NUM_DIGITS];
	logic [dafmt_pkg::LEN_W-1:0]   count_q;

	always_comb begin
		for (int i = 0; i < dafmt_pkg::NUM_DIGITS; i++) begin
			dig[i] = din.digits[(dafmt_pkg::NUM_DIGITS-1-i)*dafmt_pkg::DIGIT_W +:
				dafmt_pkg::DIGIT_W];
			ch[i]  = '0;
		end
		// leading digit position, the units digit when all others are zero
		first = 3'(dafmt_pkg::NUM_DIGITS - 1);
		for (int i = dafmt_pkg::NUM_DIGITS - 2; i >= 0; i--) begin
			if (dig[i] != '0) begin
				first = 3'(i);
			end
		end
		case (din.mode)
			dafmt_pkg::MODE_INT: begin
				for (int j = 0; j < dafmt_pkg::NUM_DIGITS; j++) begin
					if (32'(first) + j < dafmt_pkg::NUM_DIGITS) begin
						ch[j] = dafmt_pkg::ASCII_ZERO + 8'(dig[3'(32'(first) + j)]);
					end
				end
			end
			dafmt_pkg::MODE_FIXED: begin
				if (dig[0] != '0) begin
					ch[0] = dafmt_pkg::ASCII_ZERO + 8'(dig[0]);
					ch[1] = dafmt_pkg::ASCII_ZERO + 8'(dig[1]);
					ch[2] = dafmt_pkg::ASCII_POINT;
					ch[3] = dafmt_pkg::ASCII_ZERO + 8'(dig[2]);
				end else begin
					ch[0] = dafmt_pkg::ASCII_ZERO + 8'(dig[1]);
					ch[1] = dafmt_pkg::ASCII_POINT;
					ch[2] = dafmt_pkg::ASCII_ZERO + 8'(dig[2]);
				end
			end
			default: begin
				ch[0] = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (din.valid) begin
			count_q <= din.len;
		end else if (count_q != '0) begin
			count_q <= count_q - 1'b1;
		end
	end

	// load a fresh text, else advance one character
	always_ff @(posedge clk) begin
		if (din.valid) begin
			chars_q <= ch;
		end else begin
			for (int j = 0; j < dafmt_pkg::NUM_DIGITS - 1; j++) begin
				chars_q[j] <= chars_q[j+1];
			end
			chars_q[dafmt_pkg::NUM_DIGITS-1] <= '0;
		end
	end

	assign char_valid = (count_q != '0);
	assign char_code  = chars_q[0];
	assign last_char  = (count_q == dafmt_pkg::LEN_W'(1));

	a_load_on_empty: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid |-> (count_q == '0 || count_q == dafmt_pkg::LEN_W'(1)))
		else $error("new text loaded over unfinished one");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		din.valid |-> (din.len != '0 && din.len <= dafmt_pkg::LEN_W'(dafmt_pkg::NUM_DIGITS)))
		else $error("text length out of range");

endmodule

@@ rtl/decimal_ascii_formatter.sv @@
// Decimal ASCII formatter.
// Input: pulse start with value while busy is low; the value is taken at that
// clock edge. Output: one character per cycle on char_code, marked by
// char_valid, with last_char high on the final character of a value's text.
// The receiver cannot stall: every character is on the ports for one cycle.
// Configuration: cfg_data is written into format_mode when cfg_valid is high;
// cfg_ready is always high. Write it only while no text is pending.
// Mode 0 gives the integer without leading zeros (1 to 5 characters); mode 1
// treats the value as thousandths and gives "d.d" or "dd.d".
// Path: the value passes through the five digit cells, each registered, and
// then through the emitter register, whose output puts the first character
// on the ports.
// Pacing: busy is held after each accept according to the length of its
// text, as the single character port sets the pace. Values are overlapped
// in the cell chain: a new value can be taken while earlier ones are in it.
// Reset: clears format_mode to integer mode and drops any text in flight.
module decimal_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	output logic        char_valid,
	output logic [7:0]  char_code,
	output logic        last_char
);

	dafmt_pkg::cell_word_t       chain [dafmt_pkg::NUM_DIGITS+1];
	logic                        format_mode_q;
	logic [dafmt_pkg::LEN_W-1:0] hold_q;
	logic [dafmt_pkg::LEN_W-1:0] len;
	logic                        accept;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign busy      = (hold_q != '0);

	always_comb begin
		case (format_mode_q)
			dafmt_pkg::MODE_INT: begin
				if (value >= 16'd10000) begin
					len = dafmt_pkg::LEN_W'(5);
				end else if (value >= 16'd1000) begin
					len = dafmt_pkg::LEN_W'(4);
				end else if (value >= 16'd100) begin
					len = dafmt_pkg::LEN_W'(3);
				end else if (value >= 16'd10) begin
					len = dafmt_pkg::LEN_W'(2);
				end else begin
					len = dafmt_pkg::LEN_W'(1);
				end
			end
			dafmt_pkg::MODE_FIXED: begin
				len = (value >= 16'd10000) ? dafmt_pkg::LEN_W'(4) : dafmt_pkg::LEN_W'(3);
			end
			default: begin
				len = dafmt_pkg::LEN_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= dafmt_pkg::MODE_INT;
			hold_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				format_mode_q <= cfg_data;
			end
			// hold off the next word so that it reaches the emitter as this text's last character leaves the port
			if (accept) begin
				hold_q <= len - 1'b1;
			end else if (hold_q != '0) begin
				hold_q <= hold_q - 1'b1;
			end
		end
	end

	assign chain[0].valid  = accept;
	assign chain[0].mode   = format_mode_q;
	assign chain[0].len    = len;
	assign chain[0].rem    = value;
	assign chain[0].digits = '0;

	for (genvar i = 0; i < dafmt_pkg::NUM_DIGITS; i++) begin : g_cell
		dafmt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.weight (dafmt_pkg::WEIGHT[i]),
			.din    (chain[i]),
			.dout   (chain[i+1])
		);
	end

	dafmt_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (chain[dafmt_pkg::NUM_DIGITS]),
		.char_valid (char_valid),
		.char_code  (char_code),
		.last_char  (last_char)
	);

	a_first_char: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 char_valid)
		else $error("no character six cycles after accept");

	a_last_strobed: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> char_valid)
		else $error("last_char without a character");

	a_mode_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_data != format_mode_q)) |-> !busy)
		else $error("format_mode changed while a value is pending");

endmodule
